// ===== design/i2cbb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i2cbb_pkg;

   localparam int TIMER_WIDTH_DEFAULT = 16;

   localparam int CFG_WIDTH  = 16;
   localparam int ADDR_WIDTH = 4;
   localparam int DATA_WIDTH = 32;

   // command codes on req_type
   localparam logic [2:0] CMD_NONE    = 3'd0;
   localparam logic [2:0] CMD_START   = 3'd1;
   localparam logic [2:0] CMD_RSTART  = 3'd2;
   localparam logic [2:0] CMD_STOP    = 3'd3;
   localparam logic [2:0] CMD_WRITE   = 3'd4;
   localparam logic [2:0] CMD_READ    = 3'd5;
   localparam logic [2:0] CMD_RECOVER = 3'd6;

   // register indexes (byte address 4*i)
   localparam logic [1:0] REG_HALF_BIT = 2'd0;
   localparam logic [1:0] REG_SETTLE   = 2'd1;
   localparam logic [1:0] REG_STOP     = 2'd2;
   localparam logic [1:0] REG_RECOVER  = 2'd3;

   localparam logic [CFG_WIDTH-1:0] HALF_BIT_RESET = 16'd20;
   localparam logic [CFG_WIDTH-1:0] SETTLE_RESET   = 16'd200;
   localparam logic [CFG_WIDTH-1:0] STOP_RESET     = 16'd100;
   localparam logic [CFG_WIDTH-1:0] RECOVER_RESET  = 16'd5;

   localparam logic [3:0] DATA_BITS      = 4'd8;
   localparam logic [3:0] RECOVER_PULSES = 4'd9;
   localparam logic [2:0] START_LAST     = 3'd4;
   localparam logic [2:0] SHORT_LAST     = 3'd2;

endpackage

`default_nettype wire

// ===== design/i2c_bitbang_master.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    req_type, req_data_byte, req_send_ack, req_sda_sample
// rsp       out        rsp_valid/stall    rsp_scl_level, rsp_sda_level, rsp_busy_res,
//                                         rsp_done_res, rsp_read_data, rsp_ack_missing
// csr       in/out     psel/penable       paddr, pwdata, prdata (pready tied high)
//
// One tick per clock unless stalled: a tick transfer is stepped in the cycle it is accepted
// and its result appears in the output register on the next cycle, one result per tick.
// The output register is the bus state itself, so req_stall rises only while a
// result sits untaken and rsp_stall is high.
// Synchronous active-high reset puts the bus released high, idle, default timings.

module i2c_bitbang_master #(
   parameter int TIMER_WIDTH = i2cbb_pkg::TIMER_WIDTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             req_valid,
   output      logic                             req_stall,
   input  wire logic [2:0]                       req_type,
   input  wire logic [7:0]                       req_data_byte,
   input  wire logic                             req_send_ack,
   input  wire logic                             req_sda_sample,

   output      logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   output      logic                             rsp_scl_level,
   output      logic                             rsp_sda_level,
   output      logic                             rsp_busy_res,
   output      logic                             rsp_done_res,
   output      logic [7:0]                       rsp_read_data,
   output      logic                             rsp_ack_missing,

   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [i2cbb_pkg::ADDR_WIDTH-1:0] paddr,
   input  wire logic [i2cbb_pkg::DATA_WIDTH-1:0] pwdata,
   output      logic [i2cbb_pkg::DATA_WIDTH-1:0] prdata,
   output      logic                             pready
);
   import i2cbb_pkg::*;

   localparam int LenWidth = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
   localparam logic [LenWidth-1:0] TimerMax = LenWidth'({TIMER_WIDTH{1'b1}});

   // line levels {scl, sda} of a phase
   function automatic logic [1:0] phase_drive(input logic [2:0] cmd, input logic [2:0] p,
                                              input logic [3:0] bc, input logic [7:0] sr,
                                              input logic ackc, input logic [1:0] hold);
      logic [1:0] lv;
      lv = hold;
      case (cmd)
         CMD_START: begin
            unique case (p)
               3'd0:    lv = 2'b00;
               3'd1:    lv = 2'b10;
               3'd2:    lv = 2'b11;
               3'd3:    lv = 2'b10;
               default: lv = 2'b00;
            endcase
         end
         CMD_RSTART: lv = {p < 3'd2, p == 3'd0};
         CMD_STOP:   lv = {p >= 3'd1, p == 3'd2};
         CMD_WRITE:  lv = {p[0], (bc < DATA_BITS) ? sr[7] : 1'b1};
         CMD_READ:   lv = {p[0], (bc < DATA_BITS) ? 1'b1 : ~ackc};
         CMD_RECOVER: lv = {p == 3'd1, 1'b1};
         default: lv = hold;
      endcase
      return lv;
   endfunction

   logic [CFG_WIDTH-1:0] half_bit_ff, settle_ff, stop_ff, recover_ff;

   logic [2:0]             cmd_ff, cmd_in;
   logic [2:0]             phase_ff, phase_in;
   logic [3:0]             bitcnt_ff, bitcnt_in;
   logic [7:0]             shift_ff, shift_in;
   logic [TIMER_WIDTH-1:0] timer_ff, timer_in;
   logic                   ackerr_ff, ackerr_in;
   logic                   scl_ff, scl_in;
   logic                   sda_ff, sda_in;
   logic [7:0]             last_read_ff, last_read_in;
   logic                   ackc_ff, ackc_in;
   logic                   done_ff, done_in;
   logic                   valid_ff;

   logic                   req_accept;
   logic                   csr_write;
   logic [CFG_WIDTH-1:0]   len_reg;
   logic [LenWidth-1:0]    len_raw;
   logic [TIMER_WIDTH-1:0] phase_len;
   logic [1:0]             lines;
   logic                   finish;

   assign req_stall  = valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign pready     = 1'b1;
   assign csr_write  = psel & penable & pwrite;

   always_comb begin
      unique case (paddr[3:2])
         REG_HALF_BIT: prdata = DATA_WIDTH'(half_bit_ff);
         REG_SETTLE:   prdata = DATA_WIDTH'(settle_ff);
         REG_STOP:     prdata = DATA_WIDTH'(stop_ff);
         default:      prdata = DATA_WIDTH'(recover_ff);
      endcase
   end

   // length of the current phase: zero acts as one, saturate to the timer width
   always_comb begin
      case (cmd_ff) inside
         CMD_START:   len_reg = (phase_ff == 3'd2) ? settle_ff : half_bit_ff;
         CMD_STOP:    len_reg = stop_ff;
         CMD_RECOVER: len_reg = (phase_ff == 3'd0) ? half_bit_ff : recover_ff;
         CMD_RSTART, CMD_WRITE, CMD_READ: len_reg = half_bit_ff;
         default:     len_reg = CFG_WIDTH'(1);
      endcase
      len_raw = LenWidth'(len_reg);
      if (len_raw == '0) len_raw = LenWidth'(1);
      if (len_raw > TimerMax) len_raw = TimerMax;
      phase_len = len_raw[TIMER_WIDTH-1:0];
   end

   always_comb begin
      cmd_in       = cmd_ff;
      phase_in     = phase_ff;
      bitcnt_in    = bitcnt_ff;
      shift_in     = shift_ff;
      timer_in     = timer_ff;
      ackerr_in    = ackerr_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      last_read_in = last_read_ff;
      ackc_in      = ackc_ff;
      done_in      = 1'b0;
      finish       = 1'b0;
      lines        = {scl_ff, sda_ff};

      if (cmd_ff == CMD_NONE) begin
         if (req_type >= CMD_START && req_type <= CMD_RECOVER) begin
            cmd_in    = req_type;
            phase_in  = 3'd0;
            bitcnt_in = 4'd0;
            shift_in  = (req_type == CMD_WRITE) ? req_data_byte : 8'h00;
            ackc_in   = req_send_ack;
            lines     = phase_drive(req_type, 3'd0, 4'd0, shift_in, req_send_ack,
                                    {scl_ff, sda_ff});
            scl_in    = lines[1];
            sda_in    = lines[0];
            timer_in  = TIMER_WIDTH'(1);
         end
      end else if (timer_ff < phase_len) begin
         timer_in = timer_ff + TIMER_WIDTH'(1);
      end else begin
         // end of phase
         unique case (cmd_ff) inside
            CMD_START: begin
               if (phase_ff >= START_LAST) finish = 1'b1;
               else phase_in = phase_ff + 3'd1;
            end
            CMD_RSTART, CMD_STOP: begin
               if (phase_ff >= SHORT_LAST) finish = 1'b1;
               else phase_in = phase_ff + 3'd1;
            end
            CMD_WRITE, CMD_READ: begin
               if (phase_ff == 3'd0) begin
                  phase_in = 3'd1;
               end else if (bitcnt_ff >= DATA_BITS) begin
                  if (cmd_ff == CMD_WRITE) ackerr_in = req_sda_sample;
                  else last_read_in = shift_ff;
                  scl_in = 1'b0;
                  sda_in = 1'b1;
                  finish = 1'b1;
               end else begin
                  shift_in  = (cmd_ff == CMD_WRITE) ? {shift_ff[6:0], 1'b0}
                                                    : {shift_ff[6:0], req_sda_sample};
                  bitcnt_in = bitcnt_ff + 4'd1;
                  phase_in  = 3'd0;
               end
            end
            CMD_RECOVER: begin
               if (phase_ff <= 3'd1) begin
                  phase_in = phase_ff + 3'd1;
               end else begin
                  bitcnt_in = bitcnt_ff + 4'd1;
                  if (bitcnt_in >= RECOVER_PULSES) finish = 1'b1;
                  else phase_in = 3'd1;
               end
            end
            default: finish = 1'b1;
         endcase

         if (finish) begin
            cmd_in    = CMD_NONE;
            phase_in  = 3'd0;
            bitcnt_in = 4'd0;
            timer_in  = '0;
            done_in   = 1'b1;
         end else begin
            lines    = phase_drive(cmd_ff, phase_in, bitcnt_in, shift_in, ackc_ff,
                                   {scl_ff, sda_ff});
            scl_in   = lines[1];
            sda_in   = lines[0];
            timer_in = TIMER_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_bit_ff  <= HALF_BIT_RESET;
         settle_ff    <= SETTLE_RESET;
         stop_ff      <= STOP_RESET;
         recover_ff   <= RECOVER_RESET;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_HALF_BIT: half_bit_ff <= pwdata[CFG_WIDTH-1:0];
            REG_SETTLE:   settle_ff   <= pwdata[CFG_WIDTH-1:0];
            REG_STOP:     stop_ff     <= pwdata[CFG_WIDTH-1:0];
            default:      recover_ff  <= pwdata[CFG_WIDTH-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff       <= CMD_NONE;
         phase_ff     <= 3'd0;
         bitcnt_ff    <= 4'd0;
         shift_ff     <= 8'h00;
         timer_ff     <= '0;
         ackerr_ff    <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         last_read_ff <= 8'h00;
         ackc_ff      <= 1'b0;
         done_ff      <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         if (req_accept) begin
            cmd_ff       <= cmd_in;
            phase_ff     <= phase_in;
            bitcnt_ff    <= bitcnt_in;
            shift_ff     <= shift_in;
            timer_ff     <= timer_in;
            ackerr_ff    <= ackerr_in;
            scl_ff       <= scl_in;
            sda_ff       <= sda_in;
            last_read_ff <= last_read_in;
            ackc_ff      <= ackc_in;
            done_ff      <= done_in;
            valid_ff     <= 1'b1;
         end else if (~rsp_stall) begin
            valid_ff     <= 1'b0;
         end
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_scl_level   = scl_ff;
   assign rsp_sda_level   = sda_ff;
   assign rsp_busy_res    = (cmd_ff != CMD_NONE);
   assign rsp_done_res    = done_ff;
   assign rsp_read_data   = last_read_ff;
   assign rsp_ack_missing = ackerr_ff;

endmodule

`default_nettype wire

// ===== tb/sv/i2c_bitbang_master_test.sv =====
`timescale 1ns / 1ps

module i2c_bitbang_master_test;
   import i2cbb_pkg::*;

   localparam logic [2:0] CMD_UNUSED = 3'd7;

   // SDA sample patterns fed while a command runs
   localparam int SDA_LOW    = 0;
   localparam int SDA_HIGH   = 1;
   localparam int SDA_RANDOM = 2;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic [7:0] rdata;
      logic       nack;
   } bus_state_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_type = CMD_NONE;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_send_ack = 1'b0;
   logic        req_sda_sample = 1'b1;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_scl_level;
   logic        rsp_sda_level;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_read_data;
   logic        rsp_ack_missing;

   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [ADDR_WIDTH-1:0] paddr = '0;
   logic [DATA_WIDTH-1:0] pwdata = '0;
   logic [DATA_WIDTH-1:0] prdata;
   logic                  pready;

   i2c_bitbang_master i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_data_byte   (req_data_byte),
      .req_send_ack    (req_send_ack),
      .req_sda_sample  (req_sda_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_scl_level   (rsp_scl_level),
      .rsp_sda_level   (rsp_sda_level),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_read_data   (rsp_read_data),
      .rsp_ack_missing (rsp_ack_missing),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Bus master shadow: timing registers and sequencer state
   // ---------------------------------------------------------------
   logic [15:0] cfg_half    = HALF_BIT_RESET;
   logic [15:0] cfg_settle  = SETTLE_RESET;
   logic [15:0] cfg_stop    = STOP_RESET;
   logic [15:0] cfg_recover = RECOVER_RESET;

   logic [2:0]  m_cmd       = CMD_NONE;
   logic [2:0]  m_step      = '0;
   logic [3:0]  m_bits      = '0;
   logic [7:0]  m_shift     = '0;
   logic [15:0] m_timer     = '0;
   logic        m_ack_err   = 1'b0;
   logic        m_scl       = 1'b1;
   logic        m_sda       = 1'b1;
   logic [7:0]  m_last_read = '0;
   logic        m_ack_sel   = 1'b0;

   bus_state_type pending_bus_states[$];

   int          n_errors = 0;
   int unsigned tick_count = 0;
   int          sender_idle_pct = 0;
   int          rsp_stall_pct = 0;

   function automatic int unsigned ticks_of(input logic [15:0] r);
      return (r == 16'd0) ? 1 : r;
   endfunction

   // Sets line levels for the current phase, returns the phase length.
   function automatic int unsigned enter_bus_phase();
      int unsigned h;
      h = ticks_of(cfg_half);
      case (m_cmd)
         CMD_START: begin
            case (m_step)
               3'd0:    begin m_scl = 1'b0; m_sda = 1'b0; end
               3'd1:    begin m_scl = 1'b1; m_sda = 1'b0; end
               3'd2:    begin m_scl = 1'b1; m_sda = 1'b1; end
               3'd3:    begin m_scl = 1'b1; m_sda = 1'b0; end
               default: begin m_scl = 1'b0; m_sda = 1'b0; end
            endcase
            return (m_step == 3'd2) ? ticks_of(cfg_settle) : h;
         end
         CMD_RSTART: begin
            m_scl = (m_step < 3'd2);
            m_sda = (m_step == 3'd0);
            return h;
         end
         CMD_STOP: begin
            m_scl = (m_step >= 3'd1);
            m_sda = (m_step == 3'd2);
            return ticks_of(cfg_stop);
         end
         CMD_WRITE: begin
            m_scl = m_step[0];
            m_sda = (m_bits < DATA_BITS) ? m_shift[7] : 1'b1;
            return h;
         end
         CMD_READ: begin
            m_scl = m_step[0];
            m_sda = (m_bits < DATA_BITS) ? 1'b1 : ~m_ack_sel;
            return h;
         end
         CMD_RECOVER: begin
            if (m_step == 3'd0) begin
               m_scl = 1'b0;
               m_sda = 1'b1;
               return h;
            end
            m_scl = (m_step == 3'd1);
            m_sda = 1'b1;
            return ticks_of(cfg_recover);
         end
         default: return 1;
      endcase
   endfunction

   // Ends the current phase; returns 1 when the command is complete.
   function automatic bit finish_bus_phase(input logic sda);
      case (m_cmd)
         CMD_START: begin
            if (m_step >= START_LAST) return 1'b1;
            m_step++;
            return 1'b0;
         end
         CMD_RSTART, CMD_STOP: begin
            if (m_step >= SHORT_LAST) return 1'b1;
            m_step++;
            return 1'b0;
         end
         CMD_WRITE, CMD_READ: begin
            if (m_step == 3'd0) begin
               m_step = 3'd1;
               return 1'b0;
            end
            if (m_bits >= DATA_BITS) begin
               // acknowledge slot done: latch status, park SCL low, SDA released
               if (m_cmd == CMD_WRITE) m_ack_err = sda;
               else m_last_read = m_shift;
               m_scl = 1'b0;
               m_sda = 1'b1;
               return 1'b1;
            end
            if (m_cmd == CMD_WRITE) m_shift = {m_shift[6:0], 1'b0};
            else m_shift = {m_shift[6:0], sda};
            m_bits++;
            m_step = 3'd0;
            return 1'b0;
         end
         CMD_RECOVER: begin
            if (m_step <= 3'd1) begin
               m_step++;
               return 1'b0;
            end
            m_bits++;
            if (m_bits >= RECOVER_PULSES) return 1'b1;
            m_step = 3'd1;
            return 1'b0;
         end
         default: return 1'b1;
      endcase
   endfunction

   function automatic bus_state_type next_bus_state(input logic [2:0] kind,
                                                    input logic [7:0] data,
                                                    input logic ack, input logic sda);
      int unsigned   len;
      bus_state_type st;
      logic          done;
      done = 1'b0;
      if (m_cmd == CMD_NONE) begin
         if (kind >= CMD_START && kind <= CMD_RECOVER) begin
            m_cmd     = kind;
            m_step    = '0;
            m_bits    = '0;
            m_shift   = (kind == CMD_WRITE) ? data : 8'h00;
            m_ack_sel = ack;
            void'(enter_bus_phase());
            m_timer   = 16'd1;
         end
      end else begin
         len = enter_bus_phase();
         if (m_timer < len) begin
            m_timer++;
         end else if (finish_bus_phase(sda)) begin
            m_cmd   = CMD_NONE;
            m_step  = '0;
            m_bits  = '0;
            m_timer = '0;
            done    = 1'b1;
         end else begin
            void'(enter_bus_phase());
            m_timer = 16'd1;
         end
      end
      st.scl   = m_scl;
      st.sda   = m_sda;
      st.busy  = (m_cmd != CMD_NONE);
      st.done  = done;
      st.rdata = m_last_read;
      st.nack  = m_ack_err;
      return st;
   endfunction

   // ---------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------
   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         n_errors++;
      end
   endtask

   always @(posedge clock) begin
      bus_state_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bus_states.size() == 0) begin
            $display("%0t: unexpected result transfer, expected none, actual scl %0b sda %0b",
                     $time, rsp_scl_level, rsp_sda_level);
            n_errors++;
         end else begin
            want = pending_bus_states.pop_front();
            check_field("scl_level", want.scl, rsp_scl_level);
            check_field("sda_level", want.sda, rsp_sda_level);
            check_field("busy_res", want.busy, rsp_busy_res);
            check_field("done_res", want.done, rsp_done_res);
            check_field("read_data", want.rdata, rsp_read_data);
            check_field("ack_missing", want.nack, rsp_ack_missing);
         end
      end
   end

   always @(negedge clock)
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic send_tick(input logic [2:0] kind, input logic [7:0] data,
                            input logic ack, input logic sda);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_data_byte  <= data;
      req_send_ack   <= ack;
      req_sda_sample <= sda;
      do @(posedge clock); while (req_stall);
      pending_bus_states.push_back(next_bus_state(kind, data, ack, sda));
      tick_count++;
   endtask

   // Issue a command, then tick until it completes. Noisy ticks carry
   // random commands that a busy master must ignore.
   task automatic run_command(input logic [2:0] kind, input logic [7:0] data, input logic ack,
                              input int sda_mode, input bit noisy);
      logic [2:0] filler;
      logic       sda;
      sda = (sda_mode == SDA_RANDOM) ? 1'($urandom_range(1)) : (sda_mode == SDA_HIGH);
      send_tick(kind, data, ack, sda);
      while (m_cmd != CMD_NONE) begin
         filler = noisy ? 3'($urandom_range(7)) : CMD_NONE;
         sda = (sda_mode == SDA_RANDOM) ? 1'($urandom_range(1)) : (sda_mode == SDA_HIGH);
         send_tick(filler, 8'($urandom), 1'($urandom), sda);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_bus_states.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      logic [15:0] upper;
      upper = 16'($urandom);
      while (m_cmd != CMD_NONE)
         send_tick(CMD_NONE, 8'h00, 1'b0, 1'($urandom_range(1)));
      wait_drained();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {upper, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_HALF_BIT: cfg_half    = value;
         REG_SETTLE:   cfg_settle  = value;
         REG_STOP:     cfg_stop    = value;
         REG_RECOVER:  cfg_recover = value;
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_power_on_defaults();
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      repeat (3) send_tick(CMD_NONE, 8'h00, 1'b0, 1'($urandom_range(1)));
      run_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
      run_command(CMD_RSTART, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
      run_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
      run_command(CMD_RECOVER, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
      run_command(CMD_UNUSED, 8'hFF, 1'b1, SDA_RANDOM, 1'b0);
      run_command(CMD_NONE, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
   endtask

   // a zero timing register behaves as one tick
   task automatic test_zero_length();
      write_reg(REG_HALF_BIT, 16'd0);
      write_reg(REG_SETTLE, 16'd0);
      write_reg(REG_STOP, 16'd0);
      write_reg(REG_RECOVER, 16'd0);
      run_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
      run_command(CMD_WRITE, 8'h00, 1'b0, SDA_LOW, 1'b0);
      run_command(CMD_WRITE, 8'hFF, 1'b1, SDA_HIGH, 1'b0);
      run_command(CMD_READ, 8'h00, 1'b1, SDA_HIGH, 1'b0);
      run_command(CMD_READ, 8'hFF, 1'b0, SDA_LOW, 1'b0);
      run_command(CMD_WRITE, 8'hA5, 1'b0, SDA_RANDOM, 1'b1);
      run_command(CMD_WRITE, 8'($urandom), 1'b0, SDA_RANDOM, 1'b0);
      run_command(CMD_READ, 8'h00, 1'b1, SDA_RANDOM, 1'b1);
      run_command(CMD_RSTART, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
      run_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
      run_command(CMD_RECOVER, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
   endtask

   task automatic test_long_phases();
      write_reg(REG_HALF_BIT, 16'd1);
      write_reg(REG_SETTLE, 16'h0081);
      run_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
      write_reg(REG_STOP, 16'd21);
      run_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
      write_reg(REG_RECOVER, 16'd6);
      write_reg(REG_HALF_BIT, 16'd7);
      run_command(CMD_RSTART, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
   endtask

   // Mostly well-formed transfers (start, address, data, optional restart, stop)
   // with random content; the rest recovery and stray codes.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct);
      int unsigned mark;
      int          pick;
      int          n_data;
      sender_idle_pct = idle_pct;
      rsp_stall_pct   = stall_pct;
      write_reg(REG_HALF_BIT, 16'($urandom_range(3)));
      write_reg(REG_SETTLE, 16'($urandom_range(8)));
      write_reg(REG_STOP, 16'($urandom_range(4)));
      write_reg(REG_RECOVER, 16'($urandom_range(3)));
      mark = tick_count;
      while (tick_count - mark < 50) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            run_command(CMD_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 1'($urandom));
            run_command(CMD_WRITE, 8'($urandom), 1'($urandom), SDA_RANDOM, 1'($urandom));
            n_data = $urandom_range(3);
            repeat (n_data)
               run_command($urandom_range(1) ? CMD_WRITE : CMD_READ, 8'($urandom),
                           1'($urandom), SDA_RANDOM, 1'($urandom));
            if ($urandom_range(3) == 0) begin
               run_command(CMD_RSTART, 8'($urandom), 1'($urandom), SDA_RANDOM, 1'b1);
               run_command(CMD_READ, 8'($urandom), 1'($urandom), SDA_RANDOM, 1'b0);
            end
            run_command(CMD_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM, 1'($urandom));
         end else if (pick < 85) begin
            run_command(CMD_RECOVER, 8'($urandom), 1'($urandom), SDA_RANDOM, 1'($urandom));
         end else begin
            run_command(3'($urandom_range(7)), 8'($urandom), 1'($urandom),
                        SDA_RANDOM, 1'($urandom));
         end
         repeat ($urandom_range(3))
            send_tick(CMD_NONE, 8'($urandom), 1'($urandom), 1'($urandom_range(1)));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_power_on_defaults();
      test_zero_length();
      test_long_phases();
      test_random_traffic(0, 0);
      test_random_traffic(69, 0);
      test_random_traffic(0, 69);
      test_random_traffic(17, 17);
      wait_drained();
      repeat (8) @(posedge clock);
      if (n_errors == 0 && pending_bus_states.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
